// ===== rtl/hhi_pkg.sv =====
// hhi_pkg: shared widths, constants, register indexes and sideband type
// for the heightmap hillshade intensity pipeline. No dependencies.
`default_nettype none

package hhi_pkg;

    localparam int COORD_W    = 12;
    localparam int HGT_W      = 8;
    localparam int MAP_W      = 13;
    localparam int MS_W       = 17;
    localparam int CFG_W      = 16;
    localparam int IDX_W      = 3;
    localparam int Q15_W      = 16;
    localparam int LIGHT_W    = 16;
    localparam int N_W        = 10;
    localparam int L_W        = 17;
    localparam int DOT_W      = 27;
    localparam int ADOT_W     = 26;
    localparam int NN_W       = 20;
    localparam int LL_W       = 32;
    localparam int P_W        = 52;
    localparam int CMP_W      = 59;
    localparam int RAD_SHIFT  = 12;
    localparam int RAD_W      = 64;
    localparam int ROOT_W     = 32;
    localparam int REM_W      = 34;
    localparam int FRAC_SHIFT = 21;
    localparam int NUM_W      = 48;
    localparam int Q_W        = 16;
    localparam int DREM_W     = 32;

    localparam logic [Q15_W-1:0] CLAMP_Q15 = 16'd9830;
    localparam logic [Q15_W-1:0] ONE_Q15   = 16'd32768;

    localparam logic [MAP_W-1:0]   MAP_SIZE_RST = 13'd4096;
    localparam logic [Q15_W-1:0]   AMBIENT_RST  = 16'd6554;
    localparam logic [LIGHT_W-1:0] LIGHT_X_RST  = 16'hFE0C;  // -500
    localparam logic [LIGHT_W-1:0] LIGHT_Y_RST  = 16'd5000;
    localparam logic [LIGHT_W-1:0] LIGHT_Z_RST  = 16'hFE0C;  // -500

    typedef enum logic [IDX_W-1:0] {
        REG_MAP_SIZE,
        REG_AMBIENT,
        REG_LIGHT_X,
        REG_LIGHT_Y,
        REG_LIGHT_Z
    } hhi_reg_t;

    // Per-beat sideband carried alongside the arithmetic
    typedef struct packed {
        logic              border;
        logic              clamp;
        logic [ADOT_W-1:0] adot;
    } hhi_side_t;

endpackage

`default_nettype wire

// ===== rtl/hhi_front.sv =====
// hhi_front: seven-stage front end - normal and light vectors, dot product,
// squared norms, their product and the cosine clamp test. Uses hhi_pkg.
`default_nettype none

module hhi_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          ce,
    input  wire logic                          in_valid,
    input  wire logic [hhi_pkg::COORD_W-1:0]   coord_x,
    input  wire logic [hhi_pkg::COORD_W-1:0]   coord_z,
    input  wire logic [hhi_pkg::HGT_W-1:0]     height_center,
    input  wire logic [hhi_pkg::HGT_W-1:0]     height_north,
    input  wire logic [hhi_pkg::HGT_W-1:0]     height_south,
    input  wire logic [hhi_pkg::HGT_W-1:0]     height_west,
    input  wire logic [hhi_pkg::HGT_W-1:0]     height_east,
    input  wire logic [hhi_pkg::MS_W-1:0]      ms_eff,
    input  wire logic [hhi_pkg::LIGHT_W-1:0]   light_x,
    input  wire logic [hhi_pkg::LIGHT_W-1:0]   light_y,
    input  wire logic [hhi_pkg::LIGHT_W-1:0]   light_z,
    output logic                               out_valid,
    output hhi_pkg::hhi_side_t                 out_side,
    output logic [hhi_pkg::P_W-1:0]            out_p
);
    import hhi_pkg::*;

    localparam int DEPTH = 7;

    logic [DEPTH-1:0] v_reg;
    logic [DEPTH-1:0] b_reg;
    logic             border_next;

    // stage 1
    logic [HGT_W:0]           dx, dz;
    logic signed [N_W-1:0]    nx1_reg, nz1_reg, nx1_next, nz1_next;
    logic signed [L_W-1:0]    lx1_reg, ly1_reg, lz1_reg, lx1_next, ly1_next, lz1_next;
    // stage 2
    logic signed [2*N_W-1:0]  nxsq, nzsq;
    logic signed [2*L_W-1:0]  lxsq, lysq, lzsq;
    logic signed [DOT_W-1:0]  px2_reg, py2_reg, pz2_reg, px2_next, py2_next, pz2_next;
    logic [NN_W-1:0]          nxsq2_reg, nzsq2_reg;
    logic [LL_W-1:0]          lxsq2_reg, lysq2_reg, lzsq2_reg;
    // stage 3
    logic signed [DOT_W-1:0]  dot3_reg, dot3_next, dot_neg;
    logic [NN_W-1:0]          nn3_reg, nn3_next;
    logic [LL_W-1:0]          ll3_reg, ll3_next;
    // stage 4
    logic [P_W-1:0]           p4_reg, p4_next;
    logic [ADOT_W-1:0]        adot4_reg, adot4_next;
    logic                     pos4_reg, pos4_next;
    // stage 5
    logic [P_W-1:0]           sq5_reg, sq5_next, p5_reg;
    logic [ADOT_W-1:0]        adot5_reg;
    logic                     pos5_reg;
    // stage 6
    logic [CMP_W-1:0]         a6_reg, a6_next, p9_6_reg, p9_6_next;
    logic [P_W-1:0]           p6_reg;
    logic [ADOT_W-1:0]        adot6_reg;
    logic                     pos6_reg;
    // stage 7
    logic                     c7_reg, c7_next;
    logic [P_W-1:0]           p7_reg;
    logic [ADOT_W-1:0]        adot7_reg;

    always_comb begin
        border_next = (coord_x == '0) || (coord_z == '0)
                   || ((MS_W'(coord_x) + MS_W'(1)) >= ms_eff)
                   || ((MS_W'(coord_z) + MS_W'(1)) >= ms_eff);
        dx       = {1'b0, height_east} - {1'b0, height_west};
        dz       = {1'b0, height_south} - {1'b0, height_north};
        nx1_next = {dx, 1'b0};
        nz1_next = {dz, 1'b0};
        lx1_next = {light_x[LIGHT_W-1], light_x} - L_W'(coord_x);
        ly1_next = {light_y[LIGHT_W-1], light_y} - L_W'(height_center);
        lz1_next = {light_z[LIGHT_W-1], light_z} - L_W'(coord_z);
    end

    assign nxsq = nx1_reg * nx1_reg;
    assign nzsq = nz1_reg * nz1_reg;
    assign lxsq = lx1_reg * lx1_reg;
    assign lysq = ly1_reg * ly1_reg;
    assign lzsq = lz1_reg * lz1_reg;

    always_comb begin
        px2_next = nx1_reg * lx1_reg;
        pz2_next = nz1_reg * lz1_reg;
        py2_next = DOT_W'(ly1_reg) <<< 2;   // ny is fixed at 4
        dot3_next = px2_reg + py2_reg + pz2_reg;
        nn3_next  = nxsq2_reg + nzsq2_reg + NN_W'(16);
        ll3_next  = lxsq2_reg + lysq2_reg + lzsq2_reg;
        dot_neg    = -dot3_reg;
        p4_next    = nn3_reg * ll3_reg;
        adot4_next = dot3_reg[DOT_W-1] ? dot_neg[ADOT_W-1:0] : dot3_reg[ADOT_W-1:0];
        pos4_next  = !dot3_reg[DOT_W-1] && (dot3_reg != '0);
        sq5_next   = adot4_reg * adot4_reg;
        a6_next    = (CMP_W'(sq5_reg) << 6) + (CMP_W'(sq5_reg) << 5) + (CMP_W'(sq5_reg) << 2);
        p9_6_next  = (CMP_W'(p5_reg) << 3) + CMP_W'(p5_reg);
        // cosine above 0.3: 100*D^2 > 9*P with D positive
        c7_next    = pos6_reg && (a6_reg > p9_6_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (ce) begin
            v_reg <= {v_reg[DEPTH-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            b_reg     <= {b_reg[DEPTH-2:0], border_next};
            nx1_reg   <= nx1_next;
            nz1_reg   <= nz1_next;
            lx1_reg   <= lx1_next;
            ly1_reg   <= ly1_next;
            lz1_reg   <= lz1_next;
            px2_reg   <= px2_next;
            py2_reg   <= py2_next;
            pz2_reg   <= pz2_next;
            nxsq2_reg <= nxsq[NN_W-1:0];
            nzsq2_reg <= nzsq[NN_W-1:0];
            lxsq2_reg <= lxsq[LL_W-1:0];
            lysq2_reg <= lysq[LL_W-1:0];
            lzsq2_reg <= lzsq[LL_W-1:0];
            dot3_reg  <= dot3_next;
            nn3_reg   <= nn3_next;
            ll3_reg   <= ll3_next;
            p4_reg    <= p4_next;
            adot4_reg <= adot4_next;
            pos4_reg  <= pos4_next;
            sq5_reg   <= sq5_next;
            p5_reg    <= p4_reg;
            adot5_reg <= adot4_reg;
            pos5_reg  <= pos4_reg;
            a6_reg    <= a6_next;
            p9_6_reg  <= p9_6_next;
            p6_reg    <= p5_reg;
            adot6_reg <= adot5_reg;
            pos6_reg  <= pos5_reg;
            c7_reg    <= c7_next;
            p7_reg    <= p6_reg;
            adot7_reg <= adot6_reg;
        end
    end

    assign out_valid       = v_reg[DEPTH-1];
    assign out_side.border = b_reg[DEPTH-1];
    assign out_side.clamp  = c7_reg;
    assign out_side.adot   = adot7_reg;
    assign out_p           = p7_reg;

endmodule

`default_nettype wire

// ===== rtl/hhi_sqrt.sv =====
// hhi_sqrt: pipelined integer square root of P*4096, one result bit per
// stage, digit-by-digit recurrence. Uses hhi_pkg.
`default_nettype none

module hhi_sqrt (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       ce,
    input  wire logic                       in_valid,
    input  hhi_pkg::hhi_side_t              in_side,
    input  wire logic [hhi_pkg::P_W-1:0]    in_p,
    output logic                            out_valid,
    output hhi_pkg::hhi_side_t              out_side,
    output logic [hhi_pkg::ROOT_W-1:0]      out_root
);
    import hhi_pkg::*;

    logic [ROOT_W-1:0] v_reg;
    hhi_side_t         side_reg [ROOT_W];
    logic [RAD_W-1:0]  rad_reg  [ROOT_W];
    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (ce) begin
            v_reg <= {v_reg[ROOT_W-2:0], in_valid};
        end
    end

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [RAD_W-1:0]  rad_in;
        logic [REM_W-1:0]  rem_in, rem_sh, trial, rem_next;
        logic [ROOT_W-1:0] root_in;
        hhi_side_t         side_in;
        logic              ge;

        if (k == 0) begin : g_first
            assign rad_in  = {in_p, {RAD_SHIFT{1'b0}}};
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = in_side;
        end else begin : g_next
            assign rad_in  = rad_reg[k-1];
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        always_comb begin
            rem_sh   = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
            trial    = {root_in, 2'b01};
            ge       = (rem_sh >= trial);
            rem_next = ge ? (rem_sh - trial) : rem_sh;
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rad_reg[k]  <= rad_in << 2;
                rem_reg[k]  <= rem_next;
                root_reg[k] <= {root_in[ROOT_W-2:0], ge};
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];

endmodule

`default_nettype wire

// ===== rtl/hhi_div.sv =====
// hhi_div: pipelined restoring divider, (|D|*2^21 + S/2) / S, one quotient
// bit per stage; flags a zero divisor. Uses hhi_pkg.
`default_nettype none

module hhi_div (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       ce,
    input  wire logic                       in_valid,
    input  hhi_pkg::hhi_side_t              in_side,
    input  wire logic [hhi_pkg::ROOT_W-1:0] in_root,
    output logic                            out_valid,
    output hhi_pkg::hhi_side_t              out_side,
    output logic                            out_zero,
    output logic [hhi_pkg::Q_W-1:0]         out_q
);
    import hhi_pkg::*;

    logic [NUM_W-1:0]  num;
    logic [Q_W-1:0]    v_reg;
    logic [Q_W-1:0]    z_reg;
    hhi_side_t         side_reg [Q_W];
    logic [DREM_W-1:0] rem_reg  [Q_W];
    logic [Q_W-1:0]    low_reg  [Q_W];
    logic [Q_W-1:0]    q_reg    [Q_W];
    logic [ROOT_W-1:0] den_reg  [Q_W];

    // quotient never exceeds 2^15, so the top bits start below the divisor
    assign num = {(NUM_W - ADOT_W - FRAC_SHIFT)'(0), in_side.adot, {FRAC_SHIFT{1'b0}}}
               + NUM_W'(in_root >> 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (ce) begin
            v_reg <= {v_reg[Q_W-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            z_reg <= {z_reg[Q_W-2:0], (in_root == '0)};
        end
    end

    for (genvar k = 0; k < Q_W; k++) begin : g_stage
        logic [DREM_W-1:0] rem_in, rem_next;
        logic [Q_W-1:0]    low_in, q_in;
        logic [ROOT_W-1:0] den_in;
        hhi_side_t         side_in;
        logic [DREM_W:0]   t, diff;
        logic              ge;

        if (k == 0) begin : g_first
            assign rem_in  = num[NUM_W-1:Q_W];
            assign low_in  = num[Q_W-1:0];
            assign q_in    = '0;
            assign den_in  = in_root;
            assign side_in = in_side;
        end else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign low_in  = low_reg[k-1];
            assign q_in    = q_reg[k-1];
            assign den_in  = den_reg[k-1];
            assign side_in = side_reg[k-1];
        end

        always_comb begin
            t        = {rem_in, low_in[Q_W-1]};
            ge       = (t >= (DREM_W+1)'(den_in));
            diff     = t - (DREM_W+1)'(den_in);
            rem_next = ge ? diff[DREM_W-1:0] : t[DREM_W-1:0];
        end

        always_ff @(posedge aclk) begin
            if (ce) begin
                rem_reg[k]  <= rem_next;
                low_reg[k]  <= low_in << 1;
                q_reg[k]    <= {q_in[Q_W-2:0], ge};
                den_reg[k]  <= den_in;
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid = v_reg[Q_W-1];
    assign out_zero  = z_reg[Q_W-1];
    assign out_side  = side_reg[Q_W-1];
    assign out_q     = q_reg[Q_W-1];

endmodule

`default_nettype wire

// ===== rtl/hhi_skid.sv =====
// hhi_skid: output register plus skid register; registered ready toward
// the pipeline so a downstream stall never ripples back. Uses hhi_pkg.
`default_nettype none

module hhi_skid (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       in_valid,
    input  wire logic [hhi_pkg::Q15_W-1:0]  in_data,
    output logic                            in_ready,
    output logic                            out_valid,
    output logic [hhi_pkg::Q15_W-1:0]       out_data,
    input  wire logic                       out_ready
);
    import hhi_pkg::*;

    logic             out_valid_reg, skid_valid_reg;
    logic [Q15_W-1:0] out_data_reg, skid_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= in_valid;
            end
        end else if (in_valid && !skid_valid_reg) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready || !out_valid_reg) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : in_data;
        end else if (!skid_valid_reg) begin
            skid_data_reg <= in_data;
        end
    end

    assign in_ready  = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== rtl/heightmap_hillshade_intensity.sv =====
// heightmap_hillshade_intensity: top level - config registers, front end,
// square root and divider pipelines, final shade sum, output skid stage.
// Depends on hhi_pkg, hhi_front, hhi_sqrt, hhi_div, hhi_skid.
`default_nettype none

// Lambert hillshade with a point light, one vertex per beat. Each input beat
// carries a vertex position and the heights of it and its four neighbors;
// each output beat is the Q1.15 intensity (32768 = 1.0) of that vertex, in
// order. Vertices on the map border (coordinate 0 or >= map_size-1, with
// map_size capped at MAX_MAP_SIZE) give 0. Inner vertices give
// min(ambient + |cos|, 1.0), where cos is rounded to nearest Q1.15 and
// replaced by 0.3 when it exceeds 0.3. Throughput is one beat per clock
// while s_ready is high. Each beat passes through 7 front-end stages
// (vectors, dot product, norms, clamp test), 32 square-root stages (one root
// bit each, 64-bit radicand), 16 divider stages (one quotient bit each),
// one sum/saturate stage and the output register. The whole pipeline
// advances together; a two-entry output stage absorbs a stall, so s_ready
// drops only once the skid register is occupied. Configuration registers are
// sampled live and must only be written while the pipeline is empty.

module heightmap_hillshade_intensity #(
    parameter int MAX_MAP_SIZE = 4096
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // config write port
    input  wire logic                          cfg_wr_en,
    input  wire logic [hhi_pkg::IDX_W-1:0]     cfg_index,
    input  wire logic [hhi_pkg::CFG_W-1:0]     cfg_wdata,
    // input beats
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [hhi_pkg::COORD_W-1:0]   s_coord_x,
    input  wire logic [hhi_pkg::COORD_W-1:0]   s_coord_z,
    input  wire logic [hhi_pkg::HGT_W-1:0]     s_height_center,
    input  wire logic [hhi_pkg::HGT_W-1:0]     s_height_north,
    input  wire logic [hhi_pkg::HGT_W-1:0]     s_height_south,
    input  wire logic [hhi_pkg::HGT_W-1:0]     s_height_west,
    input  wire logic [hhi_pkg::HGT_W-1:0]     s_height_east,
    // result beats
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [hhi_pkg::Q15_W-1:0]          m_intensity
);
    import hhi_pkg::*;

    localparam logic [MS_W-1:0] MAX_MS = MS_W'(MAX_MAP_SIZE);

    // configuration registers
    logic [MAP_W-1:0]   map_size_reg;
    logic [Q15_W-1:0]   ambient_reg;
    logic [LIGHT_W-1:0] light_x_reg, light_y_reg, light_z_reg;
    logic [MS_W-1:0]    ms_eff;

    // pipeline plumbing
    logic               ce;
    logic               front_valid, sqrt_valid, div_valid, div_zero;
    hhi_side_t          front_side, sqrt_side, div_side;
    logic [P_W-1:0]     front_p;
    logic [ROOT_W-1:0]  sqrt_root;
    logic [Q_W-1:0]     div_q;

    // final stage
    logic [Q15_W-1:0]   term;
    logic [Q15_W:0]     sum;
    logic               fin_valid_reg;
    logic [Q15_W-1:0]   fin_data_reg, fin_data_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_size_reg <= MAP_SIZE_RST;
            ambient_reg  <= AMBIENT_RST;
            light_x_reg  <= LIGHT_X_RST;
            light_y_reg  <= LIGHT_Y_RST;
            light_z_reg  <= LIGHT_Z_RST;
        end else if (cfg_wr_en) begin
            unique case (hhi_reg_t'(cfg_index))
                REG_MAP_SIZE: map_size_reg <= cfg_wdata[MAP_W-1:0];
                REG_AMBIENT:  ambient_reg  <= cfg_wdata;
                REG_LIGHT_X:  light_x_reg  <= cfg_wdata;
                REG_LIGHT_Y:  light_y_reg  <= cfg_wdata;
                REG_LIGHT_Z:  light_z_reg  <= cfg_wdata;
                default: ;  // unmapped index, dropped
            endcase
        end
    end

    // oversized map acts as the largest supported one
    assign ms_eff = (MS_W'(map_size_reg) > MAX_MS) ? MAX_MS : MS_W'(map_size_reg);

    // every stage moves on ce; ce drops only while the skid register holds a beat
    assign s_ready = ce;

    hhi_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ce            (ce),
        .in_valid      (s_valid),
        .coord_x       (s_coord_x),
        .coord_z       (s_coord_z),
        .height_center (s_height_center),
        .height_north  (s_height_north),
        .height_south  (s_height_south),
        .height_west   (s_height_west),
        .height_east   (s_height_east),
        .ms_eff        (ms_eff),
        .light_x       (light_x_reg),
        .light_y       (light_y_reg),
        .light_z       (light_z_reg),
        .out_valid     (front_valid),
        .out_side      (front_side),
        .out_p         (front_p)
    );

    hhi_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (front_valid),
        .in_side   (front_side),
        .in_p      (front_p),
        .out_valid (sqrt_valid),
        .out_side  (sqrt_side),
        .out_root  (sqrt_root)
    );

    hhi_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ce        (ce),
        .in_valid  (sqrt_valid),
        .in_side   (sqrt_side),
        .in_root   (sqrt_root),
        .out_valid (div_valid),
        .out_side  (div_side),
        .out_zero  (div_zero),
        .out_q     (div_q)
    );

    // shade term: clamped cosine, zero when the light sits on the vertex
    always_comb begin
        if (div_side.clamp) begin
            term = CLAMP_Q15;
        end else if (div_zero) begin
            term = '0;
        end else begin
            term = div_q;
        end
        sum = (Q15_W+1)'(ambient_reg) + (Q15_W+1)'(term);
        if (div_side.border) begin
            fin_data_next = '0;
        end else if (sum > (Q15_W+1)'(ONE_Q15)) begin
            fin_data_next = ONE_Q15;
        end else begin
            fin_data_next = sum[Q15_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fin_valid_reg <= 1'b0;
        end else if (ce) begin
            fin_valid_reg <= div_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            fin_data_reg <= fin_data_next;
        end
    end

    hhi_skid u_skid (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (fin_valid_reg),
        .in_data   (fin_data_reg),
        .in_ready  (ce),
        .out_valid (m_valid),
        .out_data  (m_intensity),
        .out_ready (m_ready)
    );

    // intensity never exceeds 1.0
    a_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_intensity <= ONE_Q15))
        else $error("intensity above 1.0");

    // rounded |cos| quotient stays within 1.0 for a nonzero divisor
    a_quot: assert property (@(posedge aclk) disable iff (!aresetn)
        (div_valid && !div_zero) |-> (div_q <= ONE_Q15))
        else $error("divider quotient out of range");

    // a held pipeline keeps its beats in place
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (!ce) |=> ($stable(div_valid) && $stable(fin_valid_reg)))
        else $error("pipeline moved while stalled");

endmodule

`default_nettype wire
